/* rtl/tslnf_pkg.sv */
// Package for the text stream line-numbering filter.
// Holds byte and field types, configuration register indexes and the ASCII codes used.
// Depends on nothing; every other file takes names from it by scope.
`timescale 1ns / 1ps

package tslnf_pkg;

  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [1:0]            number_mode_t;

  localparam cfg_idx_t REG_NUMBER_MODE      = 3'd0;
  localparam cfg_idx_t REG_SQUEEZE_BLANK    = 3'd1;
  localparam cfg_idx_t REG_SHOW_ENDS        = 3'd2;
  localparam cfg_idx_t REG_SHOW_TABS        = 3'd3;
  localparam cfg_idx_t REG_SHOW_NONPRINTING = 3'd4;

  localparam byte_t CH_TAB      = 8'd9;
  localparam byte_t CH_NEWLINE  = 8'd10;
  localparam byte_t CH_SPACE    = 8'd32;
  localparam byte_t CH_DOLLAR   = 8'd36;
  localparam byte_t CH_QUESTION = 8'd63;
  localparam byte_t CH_UPPER_I  = 8'd73;
  localparam byte_t CH_CARET    = 8'd94;
  localparam byte_t CH_DELETE   = 8'd127;
  localparam byte_t CTRL_OFFSET = 8'd64;
  localparam byte_t CTRL_LIMIT  = 8'd32;
  localparam logic [3:0] DIGIT_ZONE = 4'h3;

endpackage

/* rtl/tslnf_if.sv */
// Channel interfaces for the text stream line-numbering filter.
// Input byte channel, result byte channel and configuration write channel.
// Depends on tslnf_pkg for the payload types.
`timescale 1ns / 1ps

interface tslnf_in_if;
  logic          valid;
  logic          ready;
  logic          kind;
  tslnf_pkg::byte_t data_byte;
  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface tslnf_out_if;
  logic          valid;
  logic          ready;
  tslnf_pkg::byte_t out_byte;
  logic          last;
  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

interface tslnf_cfg_if;
  logic                 valid;
  logic                 ready;
  tslnf_pkg::cfg_idx_t  index;
  tslnf_pkg::cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/text_stream_line_numbering_filter.sv */
// Top level of the text stream line-numbering filter.
// Depends on tslnf_pkg and the channel interfaces in tslnf_if.sv.
// Channel     Direction  Payload
// data_ch     sink       kind, data_byte
// result_ch   source     out_byte, last
// cfg         sink       index, data (always ready)
// A plain byte makes one result byte; a byte that expands makes one result byte per cycle,
// up to NUMBER_DIGITS + 3 with a line number, while the single result register is free.
// A start-of-file item or a squeezed blank line makes no result.
// Reset clears the configuration to zero, the line number to one and the line state.
// The next item is accepted while the last byte of the current one moves to the
// result register, so a stalled result side holds one pending item and one result.
`timescale 1ns / 1ps

module text_stream_line_numbering_filter #(
  parameter int NUMBER_DIGITS = 6
) (
  input logic        clk,
  input logic        rst,
  tslnf_in_if.sink   data_ch,
  tslnf_out_if.source result_ch,
  tslnf_cfg_if.sink  cfg
);

  localparam int NUM_W = 4 * NUMBER_DIGITS;
  localparam int IDX_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(NUMBER_DIGITS - 1);
  localparam logic [NUM_W-1:0] NUM_ONE = NUM_W'(1);

  typedef enum logic [2:0] {
    PH_DIGIT,
    PH_TAB,
    PH_DOLLAR,
    PH_CARET,
    PH_CHAR
  } phase_t;

  tslnf_pkg::number_mode_t number_mode;
  logic squeeze_blank, show_ends, show_tabs, show_nonprinting;

  logic [NUM_W-1:0] line_number;
  logic             prev_nl;
  logic             blank_seen;

  logic             job_valid;
  phase_t           phase;
  logic [IDX_W-1:0] digit_idx;
  logic [NUM_W-1:0] job_number;
  logic             job_dollar, job_caret;
  tslnf_pkg::byte_t job_char;

  logic             out_valid;
  tslnf_pkg::byte_t out_byte;
  logic             out_last;

  logic             data_accept, out_free, emit, job_done;
  logic             is_nl, is_tab_shown, drop, do_num, dollar, caret, blank_next;
  tslnf_pkg::byte_t ch_tab, ch_final;
  phase_t           start_phase, phase_next;
  logic [NUM_W-1:0] number_inc;
  logic [NUMBER_DIGITS:0] nines_below;
  logic [NUMBER_DIGITS-1:0] lead;
  logic [3:0]       digit;
  tslnf_pkg::byte_t emit_byte;

  assign cfg.ready        = 1'b1;
  assign out_free         = !out_valid || result_ch.ready;
  assign emit             = job_valid && out_free;
  assign job_done         = emit && (phase == PH_CHAR);
  assign data_ch.ready    = !job_valid || job_done;
  assign data_accept      = data_ch.valid && data_ch.ready;
  assign result_ch.valid    = out_valid;
  assign result_ch.out_byte = out_byte;
  assign result_ch.last     = out_last;

  always_comb begin
    is_nl        = (data_ch.data_byte == tslnf_pkg::CH_NEWLINE);
    drop         = squeeze_blank && prev_nl && is_nl && blank_seen;
    blank_next   = squeeze_blank && prev_nl && is_nl;
    do_num       = prev_nl && (number_mode[1] ? !is_nl : number_mode[0]);
    dollar       = show_ends && is_nl;
    is_tab_shown = show_tabs && (data_ch.data_byte == tslnf_pkg::CH_TAB);
    ch_tab       = is_tab_shown ? tslnf_pkg::CH_UPPER_I : data_ch.data_byte;
    caret        = is_tab_shown;
    ch_final     = ch_tab;
    if (show_nonprinting) begin
      if ((ch_tab < tslnf_pkg::CTRL_LIMIT) && (ch_tab != tslnf_pkg::CH_NEWLINE) &&
          (ch_tab != tslnf_pkg::CH_TAB)) begin
        caret    = 1'b1;
        ch_final = ch_tab + tslnf_pkg::CTRL_OFFSET;
      end else if (ch_tab == tslnf_pkg::CH_DELETE) begin
        caret    = 1'b1;
        ch_final = tslnf_pkg::CH_QUESTION;
      end
    end
    if (do_num) begin
      start_phase = PH_DIGIT;
    end else if (dollar) begin
      start_phase = PH_DOLLAR;
    end else if (caret) begin
      start_phase = PH_CARET;
    end else begin
      start_phase = PH_CHAR;
    end
  end

  // Saturating BCD increment: a digit steps when every digit below it is nine.
  always_comb begin
    nines_below[0] = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      nines_below[i+1] = nines_below[i] && (line_number[4*i +: 4] == 4'd9);
    end
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (nines_below[NUMBER_DIGITS] || !nines_below[i]) begin
        number_inc[4*i +: 4] = line_number[4*i +: 4];
      end else if (line_number[4*i +: 4] >= 4'd9) begin
        number_inc[4*i +: 4] = 4'd0;
      end else begin
        number_inc[4*i +: 4] = line_number[4*i +: 4] + 4'd1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      lead[i] = ((job_number >> (4 * i)) == '0) && (i != 0);
    end
    digit = job_number[4*digit_idx +: 4];
    if (digit > 4'd9) begin
      digit = 4'd9;
    end
    case (phase)
      PH_DIGIT: begin
        emit_byte  = lead[digit_idx] ? tslnf_pkg::CH_SPACE : {tslnf_pkg::DIGIT_ZONE, digit};
        phase_next = (digit_idx == '0) ? PH_TAB : PH_DIGIT;
      end
      PH_TAB: begin
        emit_byte  = tslnf_pkg::CH_TAB;
        phase_next = job_dollar ? PH_DOLLAR : (job_caret ? PH_CARET : PH_CHAR);
      end
      PH_DOLLAR: begin
        emit_byte  = tslnf_pkg::CH_DOLLAR;
        phase_next = job_caret ? PH_CARET : PH_CHAR;
      end
      PH_CARET: begin
        emit_byte  = tslnf_pkg::CH_CARET;
        phase_next = PH_CHAR;
      end
      default: begin
        emit_byte  = job_char;
        phase_next = PH_CHAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_mode      <= '0;
      squeeze_blank    <= 1'b0;
      show_ends        <= 1'b0;
      show_tabs        <= 1'b0;
      show_nonprinting <= 1'b0;
      line_number      <= NUM_ONE;
      prev_nl          <= 1'b1;
      blank_seen       <= 1'b0;
      job_valid        <= 1'b0;
      phase            <= PH_CHAR;
      digit_idx        <= IDX_TOP;
      out_valid        <= 1'b0;
      out_last         <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          tslnf_pkg::REG_NUMBER_MODE:      number_mode      <= cfg.data[1:0];
          tslnf_pkg::REG_SQUEEZE_BLANK:    squeeze_blank    <= cfg.data[0];
          tslnf_pkg::REG_SHOW_ENDS:        show_ends        <= cfg.data[0];
          tslnf_pkg::REG_SHOW_TABS:        show_tabs        <= cfg.data[0];
          tslnf_pkg::REG_SHOW_NONPRINTING: show_nonprinting <= cfg.data[0];
          default: ;
        endcase
      end

      if (emit) begin
        out_valid <= 1'b1;
        out_byte  <= emit_byte;
        out_last  <= (phase == PH_CHAR);
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end

      if (data_accept && !data_ch.kind && !drop) begin
        job_valid  <= 1'b1;
        phase      <= start_phase;
        digit_idx  <= IDX_TOP;
        job_number <= line_number;
        job_dollar <= dollar;
        job_caret  <= caret;
        job_char   <= ch_final;
      end else if (emit) begin
        phase <= phase_next;
        if (phase == PH_DIGIT) begin
          digit_idx <= digit_idx - IDX_W'(1);
        end
        if (job_done) begin
          job_valid <= 1'b0;
        end
      end

      if (data_accept) begin
        if (data_ch.kind) begin
          line_number <= NUM_ONE;
          prev_nl     <= 1'b1;
          blank_seen  <= 1'b0;
        end else if (!drop) begin
          prev_nl    <= is_nl;
          blank_seen <= blank_next;
          if (do_num) begin
            line_number <= number_inc;
          end
        end
      end
    end
  end

  a_sof_restarts: assert property (@(posedge clk) disable iff (rst)
    data_accept && data_ch.kind |=> (line_number == NUM_ONE) && prev_nl && !blank_seen)
    else $error("start of file did not restart the line state");

  a_number_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_number != '0)
    else $error("line number counter reached zero");

  a_prefix_not_last: assert property (@(posedge clk) disable iff (rst)
    emit && (phase != PH_CHAR) |=> out_valid && !out_last)
    else $error("prefix byte marked as last");

  a_digits_count_down: assert property (@(posedge clk) disable iff (rst)
    emit && (phase == PH_DIGIT) && (digit_idx != '0) && !data_accept |=> phase == PH_DIGIT)
    else $error("line number prefix cut short");

endmodule

/* test/tb.sv */
// Testbench for the text stream line-numbering filter: line numbering, blank squeezing and
// caret/dollar display checked byte for byte against an in-bench prediction of the text.
// Depends on tslnf_pkg, the channel interfaces in tslnf_if.sv and the filter top level.
`timescale 1ns / 1ps

module tb;

  localparam int DIGITS       = 6;
  localparam int LIMIT        = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 20;
  localparam int COUNT_LINES  = 110;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_FILE = 1'b1;

  localparam tslnf_pkg::number_mode_t MODE_OFF      = 2'd0;
  localparam tslnf_pkg::number_mode_t MODE_ALL      = 2'd1;
  localparam tslnf_pkg::number_mode_t MODE_NONBLANK = 2'd2;
  localparam tslnf_pkg::number_mode_t MODE_BOTH     = 2'd3;

  localparam tslnf_pkg::cfg_idx_t REG_SPARE_LOW  = 3'd5;
  localparam tslnf_pkg::cfg_idx_t REG_SPARE_HIGH = 3'd7;

  localparam int STALL_NONE     = 0;
  localparam int STALL_LIGHT    = 1;
  localparam int STALL_HEAVY    = 2;
  localparam int STALL_PERIODIC = 3;

  typedef struct packed {
    tslnf_pkg::byte_t text;
    logic             last;
  } text_item_t;

  class listing_scoreboard;
    tslnf_pkg::number_mode_t number_mode;
    logic                  squeeze;
    logic                  show_ends;
    logic                  show_tabs;
    logic                  show_controls;
    logic [4*DIGITS-1:0]   line_bcd;
    logic [4*DIGITS-1:0]   top_line_bcd;
    tslnf_pkg::byte_t      prev_byte;
    int                    blank_run;
    text_item_t            expected_text[$];
    int                    mismatches;
    int                    items_seen;
    int                    bytes_seen;
    int                    writes_seen;

    function new();
      number_mode   = MODE_OFF;
      squeeze       = 1'b0;
      show_ends     = 1'b0;
      show_tabs     = 1'b0;
      show_controls = 1'b0;
      restart_file();
      top_line_bcd  = line_bcd;
    endfunction

    function void restart_file();
      line_bcd  = (4*DIGITS)'(1);
      prev_byte = tslnf_pkg::CH_NEWLINE;
      blank_run = 0;
    endfunction

    function void write_reg(tslnf_pkg::cfg_idx_t idx, tslnf_pkg::cfg_data_t d);
      writes_seen++;
      case (idx)
        tslnf_pkg::REG_NUMBER_MODE:      number_mode = d[1:0];
        tslnf_pkg::REG_SQUEEZE_BLANK:    squeeze = d[0];
        tslnf_pkg::REG_SHOW_ENDS:        show_ends = d[0];
        tslnf_pkg::REG_SHOW_TABS:        show_tabs = d[0];
        tslnf_pkg::REG_SHOW_NONPRINTING: show_controls = d[0];
        default: ;
      endcase
    endfunction

    function void expect_byte(tslnf_pkg::byte_t b, logic l);
      expected_text.push_back({b, l});
    endfunction

    function void put_line_number();
      logic       leading;
      logic [3:0] d;
      leading = 1'b1;
      for (int i = DIGITS - 1; i >= 0; i--) begin
        d = line_bcd[4*i +: 4];
        if (d > 4'd9) d = 4'd9;
        if (d != 4'd0 || i == 0) leading = 1'b0;
        expect_byte(leading ? tslnf_pkg::CH_SPACE : {tslnf_pkg::DIGIT_ZONE, d}, 1'b0);
      end
      expect_byte(tslnf_pkg::CH_TAB, 1'b0);
    endfunction

    function void bump_line_number();
      logic [4*DIGITS-1:0] sum;
      logic                carry;
      logic [4:0]          d;
      sum   = '0;
      carry = 1'b1;
      for (int i = 0; i < DIGITS; i++) begin
        d = line_bcd[4*i +: 4] + carry;
        if (d > 5'd9) begin
          d     = 5'd0;
          carry = 1'b1;
        end else begin
          carry = 1'b0;
        end
        sum[4*i +: 4] = d[3:0];
      end
      if (!carry) line_bcd = sum;
      if (line_bcd > top_line_bcd) top_line_bcd = line_bcd;
    endfunction

    function void note_item(logic kind, tslnf_pkg::byte_t b);
      tslnf_pkg::byte_t ch;
      logic             at_start;
      items_seen++;
      if (kind == KIND_FILE) begin
        restart_file();
        return;
      end
      ch       = b;
      at_start = (prev_byte == tslnf_pkg::CH_NEWLINE);
      if (squeeze && at_start) begin
        if (ch == tslnf_pkg::CH_NEWLINE) begin
          if (blank_run >= 1) begin
            blank_run = 2;
            return;
          end
          blank_run = 1;
        end else begin
          blank_run = 0;
        end
      end else begin
        blank_run = 0;
      end
      if (at_start && (number_mode == MODE_ALL ||
          ((number_mode == MODE_NONBLANK || number_mode == MODE_BOTH) &&
           ch != tslnf_pkg::CH_NEWLINE))) begin
        put_line_number();
        bump_line_number();
      end
      if (show_ends && ch == tslnf_pkg::CH_NEWLINE) expect_byte(tslnf_pkg::CH_DOLLAR, 1'b0);
      if (show_tabs && ch == tslnf_pkg::CH_TAB) begin
        expect_byte(tslnf_pkg::CH_CARET, 1'b0);
        ch = tslnf_pkg::CH_UPPER_I;
      end
      if (show_controls) begin
        if (ch < tslnf_pkg::CTRL_LIMIT && ch != tslnf_pkg::CH_NEWLINE &&
            ch != tslnf_pkg::CH_TAB) begin
          expect_byte(tslnf_pkg::CH_CARET, 1'b0);
          ch = ch + tslnf_pkg::CTRL_OFFSET;
        end else if (ch == tslnf_pkg::CH_DELETE) begin
          expect_byte(tslnf_pkg::CH_CARET, 1'b0);
          ch = tslnf_pkg::CH_QUESTION;
        end
      end
      prev_byte = ch;
      expect_byte(ch, 1'b1);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
    endfunction

    function void check_byte(tslnf_pkg::byte_t b, logic l);
      text_item_t want;
      bytes_seen++;
      if (expected_text.size() == 0) begin
        flag($sformatf("Unexpected result byte %h last %b at result %0d.",
                       b, l, bytes_seen));
        return;
      end
      want = expected_text.pop_front();
      if (want.text !== b || want.last !== l)
        flag($sformatf("Result %0d: expected byte %h last %b, got byte %h last %b.",
                       bytes_seen, want.text, want.last, b, l));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  tslnf_in_if  data_ch ();
  tslnf_out_if result_ch ();
  tslnf_cfg_if cfg ();

  text_stream_line_numbering_filter #(
    .NUMBER_DIGITS(DIGITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .data_ch  (data_ch),
    .result_ch(result_ch),
    .cfg      (cfg)
  );

  listing_scoreboard sb;

  int stall_style = STALL_NONE;
  int gap_max     = 0;
  int burst_left  = 0;
  int sent_items  = 0;
  int hold_asked  = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int stall_tick  = 0;
  int cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES;
    end
    stall_tick++;
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      case (stall_style)
        STALL_NONE:  result_ch.ready <= 1'b1;
        STALL_LIGHT: result_ch.ready <= ($urandom_range(0, 3) != 0);
        STALL_HEAVY: result_ch.ready <= ($urandom_range(0, 1) != 0);
        default:     result_ch.ready <= ((stall_tick % 7) >= 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (data_ch.valid && data_ch.ready) sb.note_item(data_ch.kind, data_ch.data_byte);
      if (result_ch.valid && result_ch.ready)
        sb.check_byte(result_ch.out_byte, result_ch.last);
      if (cfg.valid && cfg.ready) sb.write_reg(cfg.index, cfg.data);
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_item(logic kind, tslnf_pkg::byte_t b);
    data_ch.valid     <= 1'b1;
    data_ch.kind      <= kind;
    data_ch.data_byte <= b;
    do @(posedge clk); while (!data_ch.ready);
  endtask

  task automatic send_paced(logic kind, tslnf_pkg::byte_t b);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        data_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    sent_items++;
    send_item(kind, b);
  endtask

  task automatic write_reg(tslnf_pkg::cfg_idx_t idx, tslnf_pkg::cfg_data_t d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= d;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic configure(tslnf_pkg::number_mode_t mode, logic sq, logic ends, logic tabs,
                           logic ctl);
    tslnf_pkg::cfg_data_t d;
    d = tslnf_pkg::cfg_data_t'($urandom);
    d[1:0] = mode;
    write_reg(tslnf_pkg::REG_NUMBER_MODE, d);
    d = tslnf_pkg::cfg_data_t'($urandom);
    d[0] = sq;
    write_reg(tslnf_pkg::REG_SQUEEZE_BLANK, d);
    d = tslnf_pkg::cfg_data_t'($urandom);
    d[0] = ends;
    write_reg(tslnf_pkg::REG_SHOW_ENDS, d);
    d = tslnf_pkg::cfg_data_t'($urandom);
    d[0] = tabs;
    write_reg(tslnf_pkg::REG_SHOW_TABS, d);
    d = tslnf_pkg::cfg_data_t'($urandom);
    d[0] = ctl;
    write_reg(tslnf_pkg::REG_SHOW_NONPRINTING, d);
    write_reg(tslnf_pkg::cfg_idx_t'($urandom_range(REG_SPARE_LOW, REG_SPARE_HIGH)),
              tslnf_pkg::cfg_data_t'($urandom));
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    data_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.expected_text.size() != 0);
    repeat (DIGITS + 6) @(posedge clk);
  endtask

  function automatic tslnf_pkg::byte_t random_text_byte();
    case ($urandom_range(0, 9))
      0:       return tslnf_pkg::CH_TAB;
      1:       return tslnf_pkg::byte_t'($urandom_range(0, 31));
      2:       return tslnf_pkg::CH_DELETE;
      3:       return tslnf_pkg::byte_t'($urandom_range(128, 255));
      4:       return tslnf_pkg::CH_NEWLINE;
      default: return tslnf_pkg::byte_t'($urandom_range(32, 126));
    endcase
  endfunction

  task automatic send_random_line();
    int len;
    len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
    for (int i = 0; i < len; i++) send_paced(KIND_DATA, random_text_byte());
    if ($urandom_range(0, 19) == 0) send_paced(KIND_FILE, tslnf_pkg::byte_t'($urandom));
    if ($urandom_range(0, 9) != 0) send_paced(KIND_DATA, tslnf_pkg::CH_NEWLINE);
  endtask

  initial begin
    logic [3:0] flags;
    int         target;
    sb = new();
    rst                = 1'b1;
    data_ch.valid      = 1'b0;
    data_ch.kind       = KIND_DATA;
    data_ch.data_byte  = '0;
    cfg.valid          = 1'b0;
    cfg.index          = tslnf_pkg::REG_NUMBER_MODE;
    cfg.data           = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: everything passes through unchanged.
    stall_style = STALL_LIGHT;
    send_paced(KIND_DATA, 8'h61);
    send_paced(KIND_DATA, tslnf_pkg::CH_TAB);
    send_paced(KIND_DATA, 8'h01);
    send_paced(KIND_DATA, tslnf_pkg::CH_NEWLINE);
    send_paced(KIND_DATA, tslnf_pkg::CH_NEWLINE);
    drain();

    configure(MODE_ALL, 1'b1, 1'b1, 1'b1, 1'b1);
    send_paced(KIND_FILE, 8'hFF);
    send_paced(KIND_DATA, tslnf_pkg::CH_NEWLINE);
    send_paced(KIND_DATA, tslnf_pkg::CH_NEWLINE);
    send_paced(KIND_DATA, tslnf_pkg::CH_NEWLINE);
    send_paced(KIND_DATA, 8'h78);
    send_paced(KIND_DATA, tslnf_pkg::CH_TAB);
    send_paced(KIND_DATA, 8'h00);
    send_paced(KIND_DATA, 8'h1F);
    send_paced(KIND_DATA, tslnf_pkg::CH_DELETE);
    send_paced(KIND_DATA, 8'hFF);
    send_paced(KIND_DATA, tslnf_pkg::CH_NEWLINE);
    drain();

    configure(MODE_BOTH, 1'b1, 1'b0, 1'b1, 1'b0);
    send_paced(KIND_DATA, tslnf_pkg::CH_NEWLINE);
    send_paced(KIND_DATA, tslnf_pkg::CH_TAB);
    send_paced(KIND_DATA, tslnf_pkg::CH_NEWLINE);
    send_paced(KIND_DATA, tslnf_pkg::CH_NEWLINE);
    send_paced(KIND_DATA, tslnf_pkg::CH_NEWLINE);
    send_paced(KIND_DATA, 8'h80);
    send_paced(KIND_DATA, tslnf_pkg::CH_NEWLINE);
    drain();

    // Run the counter past several decimal carries at full rate.
    configure(MODE_ALL, 1'b0, 1'b1, 1'b0, 1'b0);
    stall_style = STALL_NONE;
    gap_max     = 0;
    send_paced(KIND_FILE, 8'h00);
    for (int i = 0; i < COUNT_LINES; i++) send_paced(KIND_DATA, tslnf_pkg::CH_NEWLINE);
    drain();

    for (int k = 0; k < PHASES; k++) begin
      flags = (k == 0) ? 4'hF : (k == 1) ? 4'h0 : 4'($urandom);
      configure(tslnf_pkg::number_mode_t'(k % 4), flags[0], flags[1], flags[2], flags[3]);
      stall_style = k % 4;
      gap_max     = (k % 3 == 1) ? 0 : 8;
      if (k == 2) begin
        gap_max = 0;
        hold_asked++;
      end
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) begin
        if ($urandom_range(0, 4) == 0)
          send_paced(($urandom_range(0, 15) == 0) ? KIND_FILE : KIND_DATA,
                     tslnf_pkg::byte_t'($urandom));
        else
          send_random_line();
      end
      drain();
    end

    repeat (2 * DIGITS + 8) @(posedge clk);
    $display("Covered %0d input transfers, %0d result bytes and %0d register writes.",
             sb.items_seen, sb.bytes_seen, sb.writes_seen);
    $display("Line numbers reached %0h; %0d mismatches, %0d results still owed.",
             sb.top_line_bcd, sb.mismatches, sb.expected_text.size());
    if (sb.mismatches == 0 && sb.expected_text.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tslnf_pkg.sv
rtl/tslnf_if.sv
rtl/text_stream_line_numbering_filter.sv
test/tb.sv
